// ===== sv/htw_pkg.sv =====
// Shared constants, types and the arctangent table of the heading to wheel speed turner.
package htw_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW       = $clog2(CordicSteps);
  localparam int unsigned AngW        = 17;
  localparam int unsigned ZW          = 26;
  localparam int unsigned RadW        = 36;
  localparam int unsigned DivQW       = 15;
  localparam int unsigned DivNW       = 31;

  // Turning modes.
  localparam logic [1:0] ModeNone = 2'd0;
  localparam logic [1:0] ModeSoft = 2'd1;
  localparam logic [1:0] ModeHard = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegHardThr  = 2'd0;
  localparam logic [1:0] RegSoftThr  = 2'd1;
  localparam logic [1:0] RegNoThr    = 2'd2;
  localparam logic [1:0] RegMaxSpeed = 2'd3;

  // Control of one iterative unit: load its operands, or run step idx.
  typedef struct packed {
    logic             load;
    logic             step;
    logic [StepW-1:0] idx;
  } unit_ctrl_t;

  // atan(2^-i) in binary angle units times 256, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_lut(logic [StepW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 26'sd2097152;
      4'd1:    v = 26'sd1238021;
      4'd2:    v = 26'sd654136;
      4'd3:    v = 26'sd332050;
      4'd4:    v = 26'sd166669;
      4'd5:    v = 26'sd83416;
      4'd6:    v = 26'sd41718;
      4'd7:    v = 26'sd20860;
      4'd8:    v = 26'sd10430;
      4'd9:    v = 26'sd5215;
      4'd10:   v = 26'sd2608;
      4'd11:   v = 26'sd1304;
      4'd12:   v = 26'sd652;
      4'd13:   v = 26'sd326;
      4'd14:   v = 26'sd163;
      default: v = 26'sd81;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/htw_cordic.sv =====
// Iterative CORDIC in vectoring mode that finds the heading angle, one micro-rotation a cycle.
module htw_cordic (
  input  logic                            clk_i,
  input  htw_pkg::unit_ctrl_t             ctrl_i,
  input  logic signed [15:0]              x_i,
  input  logic signed [15:0]              y_i,
  output logic signed [htw_pkg::AngW-1:0] ang_o
);

  logic signed [htw_pkg::RadW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [htw_pkg::ZW-1:0]   z_q, z_d;
  logic                            axis_q, axis_d, axis_neg_q, axis_neg_d;

  logic signed [htw_pkg::RadW-1:0] xs, ys, dx, dy;
  logic signed [htw_pkg::ZW-1:0]   zr, zsh;

  assign xs = $signed({{4{x_i[15]}}, x_i, 16'h0000});
  assign ys = $signed({{4{y_i[15]}}, y_i, 16'h0000});
  assign dx = cy_q >>> ctrl_i.idx;
  assign dy = cx_q >>> ctrl_i.idx;

  always_comb begin
    cx_d       = cx_q;
    cy_d       = cy_q;
    z_d        = z_q;
    axis_d     = axis_q;
    axis_neg_d = axis_neg_q;
    if (ctrl_i.load) begin
      axis_d     = (y_i == 16'sd0);
      axis_neg_d = x_i[15];
      // Vectors in the left half plane are first turned by a quarter turn.
      if (x_i[15] && !y_i[15]) begin
        cx_d = ys;
        cy_d = -xs;
        z_d  = 26'sd4194304;
      end else if (x_i[15]) begin
        cx_d = -ys;
        cy_d = xs;
        z_d  = -26'sd4194304;
      end else begin
        cx_d = xs;
        cy_d = ys;
        z_d  = '0;
      end
    end else if (ctrl_i.step) begin
      if (cy_q > 0) begin
        cx_d = cx_q + dx;
        cy_d = cy_q - dy;
        z_d  = z_q + htw_pkg::atan_lut(ctrl_i.idx);
      end else begin
        cx_d = cx_q - dx;
        cy_d = cy_q + dy;
        z_d  = z_q - htw_pkg::atan_lut(ctrl_i.idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    z_q        <= z_d;
    axis_q     <= axis_d;
    axis_neg_q <= axis_neg_d;
  end

  // Round the accumulator to binary angle units and clamp to half a turn.
  assign zr  = z_q + 26'sd128;
  assign zsh = zr >>> 8;

  always_comb begin
    if (axis_q) begin
      ang_o = axis_neg_q ? 17'sd32768 : 17'sd0;
    end else if (zsh > 26'sd32768) begin
      ang_o = 17'sd32768;
    end else if (zsh < -26'sd32768) begin
      ang_o = -17'sd32768;
    end else begin
      ang_o = zsh[htw_pkg::AngW-1:0];
    end
  end

endmodule

// ===== sv/htw_isqrt.sv =====
// Iterative integer square root, one result bit a cycle.
module htw_isqrt (
  input  logic                clk_i,
  input  htw_pkg::unit_ctrl_t ctrl_i,
  input  logic [31:0]         n_i,
  output logic [15:0]         root_o
);

  logic [31:0] n_q, n_d, res_q, res_d, bitv;
  logic [32:0] trial;
  logic [4:0]  sh;

  assign sh    = 5'd30 - {ctrl_i.idx, 1'b0};
  assign bitv  = 32'd1 << sh;
  assign trial = {1'b0, res_q} + {1'b0, bitv};

  always_comb begin
    n_d   = n_q;
    res_d = res_q;
    if (ctrl_i.load) begin
      n_d   = n_i;
      res_d = '0;
    end else if (ctrl_i.step) begin
      if ({1'b0, n_q} >= trial) begin
        n_d   = n_q - trial[31:0];
        res_d = (res_q >> 1) + bitv;
      end else begin
        res_d = res_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
  end

  assign root_o = res_q[15:0];

endmodule

// ===== sv/htw_div.sv =====
// Restoring divider that yields one quotient bit a cycle, most significant bit first.
module htw_div (
  input  logic                       clk_i,
  input  htw_pkg::unit_ctrl_t        ctrl_i,
  input  logic [htw_pkg::DivNW-1:0]  num_i,
  input  logic [htw_pkg::DivQW-1:0]  den_i,
  output logic [htw_pkg::DivQW-1:0]  quo_o
);

  logic [htw_pkg::DivNW-1:0] rem_q, rem_d, dsh;
  logic [htw_pkg::DivQW-1:0] quo_q, quo_d;
  logic [htw_pkg::StepW-1:0] sh;

  // The quotient is known to fit in DivQW bits, so the trial starts at that weight.
  assign sh  = htw_pkg::StepW'(htw_pkg::DivQW - 1) - ctrl_i.idx;
  assign dsh = htw_pkg::DivNW'(den_i) << sh;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      rem_d = num_i;
      quo_d = '0;
    end else if (ctrl_i.step) begin
      if (rem_q >= dsh) begin
        rem_d = rem_q - dsh;
        quo_d = {quo_q[htw_pkg::DivQW-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[htw_pkg::DivQW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// ===== sv/heading_to_wheel_speed_turner_unit.sv =====
// Top level of the heading to wheel speed turner: sequencer, mode logic and stream ports.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  heading_x, heading_y
//  m_axis    out        m_axis_tvalid / m_axis_tready  left_speed, right_speed, turn_mode
//  cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// From its transfer an item goes through squaring, unit load, 16 CORDIC and square root
// steps that run side by side, mode update, divider load, 15 divider steps and output load.
// The input is ready again as the result is shown, and not ready while an item is at work;
// a waiting result is held in the output register, and the next item is taken while it waits.
// Reset sets the thresholds and max speed to their defaults and the mode to none.
module heading_to_wheel_speed_turner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] heading_x, [31:16] heading_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] left_speed, [31:16] right_speed,
                                      // [33:32] turn_mode, [39:34] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_ITER = 3'd3;
  localparam logic [2:0] S_MODE = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                 state_q, state_d;
  logic [htw_pkg::StepW-1:0]  cnt_q, cnt_d;
  logic [1:0]                 mode_q, mode_d;
  logic                       out_valid_q, out_valid_d;
  logic [14:0]                hard_q, soft_q, none_q;
  logic [13:0]                max_q;

  logic signed [15:0]         x_q, y_q;
  logic [31:0]                xx_q;
  logic [15:0]                a_q;
  logic                       pos_q;
  logic [13:0]                base_q;
  logic [39:0]                out_q;

  logic signed [31:0]         xx_full, yy_full;
  logic [31:0]                sq;
  logic [29:0]                prod;
  logic [htw_pkg::DivNW-1:0]  num;
  logic signed [htw_pkg::AngW-1:0] ang;
  logic [15:0]                a_abs, len;
  logic [1:0]                 mode_cur, mode_upd;
  logic [14:0]                quo, d;
  logic [15:0]                s1, s2, left, right;
  logic                       in_xfer, out_xfer, out_load;

  htw_pkg::unit_ctrl_t        iter_ctrl, div_ctrl;

  assign iter_ctrl = '{load: state_q == S_LOAD, step: state_q == S_ITER, idx: cnt_q};
  assign div_ctrl  = '{load: state_q == S_MUL,  step: state_q == S_DIV,  idx: cnt_q};

  assign xx_full = x_q * x_q;
  assign yy_full = y_q * y_q;
  assign sq      = xx_q + unsigned'(yy_full);

  htw_cordic u_cordic (
    .clk_i  (clk_i),
    .ctrl_i (iter_ctrl),
    .x_i    (x_q),
    .y_i    (y_q),
    .ang_o  (ang)
  );

  htw_isqrt u_isqrt (
    .clk_i  (clk_i),
    .ctrl_i (iter_ctrl),
    .n_i    (sq),
    .root_o (len)
  );

  assign prod = base_q * a_q;
  assign num  = htw_pkg::DivNW'(prod) + htw_pkg::DivNW'(hard_q >> 1);

  htw_div u_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (num),
    .den_i  (hard_q),
    .quo_o  (quo)
  );

  assign a_abs = ang[htw_pkg::AngW-1] ? 16'(-ang) : 16'(ang);

  // Hysteresis: hard relaxes to soft, soft climbs to hard or relaxes to none, and none climbs by the thresholds.
  always_comb begin
    mode_cur = (mode_q == htw_pkg::ModeSoft || mode_q == htw_pkg::ModeHard) ?
               mode_q : htw_pkg::ModeNone;
    mode_upd = mode_cur;
    if (mode_upd == htw_pkg::ModeHard && a_abs <= {1'b0, soft_q}) begin
      mode_upd = htw_pkg::ModeSoft;
    end
    if (mode_upd == htw_pkg::ModeSoft) begin
      if (a_abs > {1'b0, hard_q}) begin
        mode_upd = htw_pkg::ModeHard;
      end else if (a_abs <= {1'b0, none_q}) begin
        mode_upd = htw_pkg::ModeNone;
      end
    end
    if (mode_upd == htw_pkg::ModeNone) begin
      if (a_abs > {1'b0, hard_q}) begin
        mode_upd = htw_pkg::ModeHard;
      end else if (a_abs > {1'b0, none_q}) begin
        mode_upd = htw_pkg::ModeSoft;
      end
    end
  end

  assign d = (hard_q == 15'd0) ? 15'd0 : quo;

  always_comb begin
    case (mode_q)
      htw_pkg::ModeSoft: begin
        s1 = 16'(base_q) - 16'(d);
        s2 = 16'(base_q) + 16'(d);
      end
      htw_pkg::ModeHard: begin
        s1 = 16'd0 - 16'(max_q);
        s2 = 16'(max_q);
      end
      default: begin
        s1 = 16'(base_q);
        s2 = 16'(base_q);
      end
    endcase
    left  = pos_q ? s1 : s2;
    right = pos_q ? s2 : s1;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cnt_d   = '0;
        state_d = S_ITER;
      end
      S_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == htw_pkg::StepW'(htw_pkg::CordicSteps - 1)) begin
          state_d = S_MODE;
        end
      end
      S_MODE: begin
        mode_d  = mode_upd;
        state_d = S_MUL;
      end
      S_MUL: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == htw_pkg::StepW'(htw_pkg::DivQW - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mode_q      <= htw_pkg::ModeNone;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_q <= 15'd16384;
      soft_q <= 15'd12743;
      none_q <= 15'd1820;
      max_q  <= 14'd2560;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        htw_pkg::RegHardThr:  hard_q <= cfg_data_i;
        htw_pkg::RegSoftThr:  soft_q <= cfg_data_i;
        htw_pkg::RegNoThr:    none_q <= cfg_data_i;
        htw_pkg::RegMaxSpeed: max_q  <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q <= $signed(s_axis_tdata[15:0]);
      y_q <= $signed(s_axis_tdata[31:16]);
    end
    if (state_q == S_SQR) begin
      xx_q <= unsigned'(xx_full);
    end
    if (state_q == S_MODE) begin
      a_q    <= a_abs;
      pos_q  <= (ang > 17'sd0);
      base_q <= (len < {2'b00, max_q}) ? len[13:0] : max_q;
    end
    if (out_load) begin
      out_q <= {6'b0, mode_q, right, left};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
